// ----- hdl/plt_pkg.sv -----
`default_nettype none

package plt_pkg;

    localparam int TABLE_DEPTH        = 16;
    localparam int PENDING_DEPTH      = 16;
    localparam int DEFAULT_MISS_LIMIT = 5;

    localparam int ADDR_W    = 32;
    localparam int MISS_W    = 4;
    localparam int TBL_IDX_W = $clog2(TABLE_DEPTH);
    localparam int TBL_CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PND_IDX_W = $clog2(PENDING_DEPTH);
    localparam int PND_CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int WALK_W    = (TBL_CNT_W > PND_CNT_W) ? TBL_CNT_W : PND_CNT_W;

    localparam logic [MISS_W-1:0] MISS_MAX   = '1;
    localparam logic [MISS_W-1:0] MISS_RESET = MISS_W'(DEFAULT_MISS_LIMIT);

    typedef enum logic [1:0] {
        KIND_REPORT    = 2'd0,
        KIND_END_ROUND = 2'd1,
        KIND_FLUSH     = 2'd2,
        KIND_UNUSED    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_DISCONNECT = 2'd0,
        EV_MEMBER     = 2'd1,
        EV_EMPTY      = 2'd2
    } event_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_RD,
        S_T_CMP,
        S_P_RD,
        S_P_CMP,
        S_E_RD,
        S_E_PROC,
        S_A_RD,
        S_A_WR,
        S_L_RD,
        S_L_EMIT,
        S_F_RD,
        S_F_EMIT
    } state_t;

    typedef struct packed {
        logic   load_item;
        logic   idx_clr;
        logic   idx_inc;
        logic   tbl_rd;
        logic   pnd_rd;
        logic   set_seen;
        logic   pnd_push;
        logic   keep_wr;
        logic   commit_w;
        logic   app_wr;
        logic   clr_round;
        logic   clr_table;
        logic   miss_clr;
        logic   emit;
        event_t emit_ev;
        logic   emit_last;
    } cmd_t;

    typedef struct packed {
        logic tbl_end;
        logic pnd_end;
        logic tbl_full;
        logic tbl_empty;
        logic key_match;
        logic pnd_match;
        logic drop;
        logic idx_final;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- hdl/peer_liveness_table.sv -----
// Peer report: scans the table entries, then the pending queue entries;
//   the table lookup and queue lookup each use the single read port of their memory.
// End of round: ages and compacts the table, appends the queued addresses (skipped once
//   the table is full), then emits member beats or one empty-list beat; waits under out_stall.
// Flush: emits a disconnect beat per entry, then empties the table. One item in flight at a time.
// Reset: table and queue empty, seen bits and miss counts zero, miss_limit 5.
`default_nettype none

module peer_liveness_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  kind,
    input  wire logic [plt_pkg::ADDR_W-1:0]  peer_addr,
    input  wire logic                        cfg_we,
    input  wire logic [plt_pkg::MISS_W-1:0]  cfg_wdata,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       event_res,
    output logic [plt_pkg::ADDR_W-1:0]       peer_addr_out,
    output logic                             last
);

    plt_pkg::cmd_t  cmd;
    plt_pkg::stat_t stat;

    plt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    plt_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .peer_addr     (peer_addr),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .peer_addr_out (peer_addr_out),
        .last          (last)
    );

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == plt_pkg::EV_EMPTY)) |-> (last && (peer_addr_out == '0)))
        else $error("empty list beat not final or address nonzero");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over an unread beat");

    a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.emit)
        else $error("result produced while controller idle");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.app_wr |-> !stat.tbl_full)
        else $error("append into full table");
`endif

endmodule

`default_nettype wire

// ----- hdl/plt_ctrl.sv -----
`default_nettype none

module plt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    kind,
    output logic               in_stall,
    input  wire plt_pkg::stat_t stat,
    output plt_pkg::cmd_t      cmd
);

    plt_pkg::state_t state_reg;
    plt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.emit_ev = plt_pkg::EV_DISCONNECT;
        state_next  = state_reg;
        in_stall    = (state_reg != plt_pkg::S_IDLE);

        unique case (state_reg)
            plt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (plt_pkg::kind_t'(kind))
                        plt_pkg::KIND_REPORT:    state_next = plt_pkg::S_T_RD;
                        plt_pkg::KIND_END_ROUND: state_next = plt_pkg::S_E_RD;
                        plt_pkg::KIND_FLUSH:     state_next = plt_pkg::S_F_RD;
                        plt_pkg::KIND_UNUSED:    state_next = plt_pkg::S_IDLE;
                    endcase
                end
            end

            // report: look up the table, then the pending queue
            plt_pkg::S_T_RD:
            begin
                if (stat.tbl_end)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = plt_pkg::S_P_RD;
                end
                else
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = plt_pkg::S_T_CMP;
                end
            end

            plt_pkg::S_T_CMP:
            begin
                if (stat.key_match)
                begin
                    cmd.set_seen = 1'b1;
                    state_next   = plt_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = plt_pkg::S_T_RD;
                end
            end

            plt_pkg::S_P_RD:
            begin
                if (stat.pnd_end)
                begin
                    cmd.pnd_push = 1'b1;
                    state_next   = plt_pkg::S_IDLE;
                end
                else
                begin
                    cmd.pnd_rd = 1'b1;
                    state_next = plt_pkg::S_P_CMP;
                end
            end

            plt_pkg::S_P_CMP:
            begin
                if (stat.pnd_match)
                begin
                    state_next = plt_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = plt_pkg::S_P_RD;
                end
            end

            // end of round: age and compact the table
            plt_pkg::S_E_RD:
            begin
                if (stat.tbl_end)
                begin
                    cmd.commit_w = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = plt_pkg::S_A_RD;
                end
                else
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = plt_pkg::S_E_PROC;
                end
            end

            plt_pkg::S_E_PROC:
            begin
                if (stat.drop)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.idx_inc = 1'b1;
                        state_next  = plt_pkg::S_E_RD;
                    end
                end
                else
                begin
                    cmd.keep_wr = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = plt_pkg::S_E_RD;
                end
            end

            // append the queued addresses
            plt_pkg::S_A_RD:
            begin
                if (stat.pnd_end)
                begin
                    cmd.clr_round = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = plt_pkg::S_L_RD;
                end
                else if (stat.tbl_full)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.pnd_rd = 1'b1;
                    state_next = plt_pkg::S_A_WR;
                end
            end

            plt_pkg::S_A_WR:
            begin
                cmd.app_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = plt_pkg::S_A_RD;
            end

            // member list
            plt_pkg::S_L_RD:
            begin
                if (stat.tbl_empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_ev   = plt_pkg::EV_EMPTY;
                        cmd.emit_last = 1'b1;
                        state_next    = plt_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = plt_pkg::S_L_EMIT;
                end
            end

            plt_pkg::S_L_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_ev   = plt_pkg::EV_MEMBER;
                    cmd.emit_last = stat.idx_final;
                    cmd.idx_inc   = 1'b1;
                    state_next    = stat.idx_final ? plt_pkg::S_IDLE : plt_pkg::S_L_RD;
                end
            end

            // flush
            plt_pkg::S_F_RD:
            begin
                if (stat.tbl_end)
                begin
                    cmd.clr_round = 1'b1;
                    cmd.clr_table = 1'b1;
                    state_next    = plt_pkg::S_IDLE;
                end
                else
                begin
                    cmd.tbl_rd = 1'b1;
                    state_next = plt_pkg::S_F_EMIT;
                end
            end

            plt_pkg::S_F_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = stat.idx_final;
                    cmd.miss_clr  = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = plt_pkg::S_F_RD;
                end
            end

            default:
            begin
                state_next = plt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/plt_dpath.sv -----
`default_nettype none

module plt_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [plt_pkg::ADDR_W-1:0]  peer_addr,
    input  wire logic                        cfg_we,
    input  wire logic [plt_pkg::MISS_W-1:0]  cfg_wdata,
    input  wire plt_pkg::cmd_t               cmd,
    output plt_pkg::stat_t                   stat,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       event_res,
    output logic [plt_pkg::ADDR_W-1:0]       peer_addr_out,
    output logic                             last
);

    localparam int AW = plt_pkg::ADDR_W;
    localparam int MW = plt_pkg::MISS_W;
    localparam int TI = plt_pkg::TBL_IDX_W;
    localparam int TC = plt_pkg::TBL_CNT_W;
    localparam int PI = plt_pkg::PND_IDX_W;
    localparam int PC = plt_pkg::PND_CNT_W;
    localparam int WW = plt_pkg::WALK_W;

    logic [AW-1:0] key_mem [plt_pkg::TABLE_DEPTH];
    logic [AW-1:0] pnd_mem [plt_pkg::PENDING_DEPTH];
    logic [AW-1:0] key_rdata_reg;
    logic [AW-1:0] pnd_rdata_reg;

    logic [MW-1:0] miss_reg [plt_pkg::TABLE_DEPTH];
    logic [plt_pkg::TABLE_DEPTH-1:0] seen_reg;

    logic [TC-1:0] peer_count_reg;
    logic [PC-1:0] pending_count_reg;
    logic [WW-1:0] idx_reg;
    logic [TC-1:0] w_reg;
    logic [AW-1:0] addr_reg;
    logic [MW-1:0] miss_limit_reg;

    logic                 out_valid_reg;
    plt_pkg::event_t      out_event_reg;
    logic [AW-1:0]        out_addr_reg;
    logic                 out_last_reg;

    logic [TI-1:0] idx_t;
    logic [PI-1:0] idx_p;
    logic          key_we;
    logic [TI-1:0] key_waddr;
    logic [AW-1:0] key_wdata;
    logic [MW-1:0] miss_cur;
    logic [MW-1:0] miss_inc;
    logic [MW-1:0] keep_count;
    logic          out_free;

    assign idx_t = idx_reg[TI-1:0];
    assign idx_p = idx_reg[PI-1:0];

    // saturating miss count of the entry under the walk
    assign miss_cur   = miss_reg[idx_t];
    assign miss_inc   = (miss_cur == plt_pkg::MISS_MAX) ? miss_cur : miss_cur + MW'(1);
    assign keep_count = seen_reg[idx_t] ? '0 : miss_inc;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.tbl_end   = (idx_reg >= WW'(peer_count_reg));
        stat.pnd_end   = (idx_reg >= WW'(pending_count_reg));
        stat.tbl_full  = (peer_count_reg == TC'(plt_pkg::TABLE_DEPTH));
        stat.tbl_empty = (peer_count_reg == '0);
        stat.key_match = (key_rdata_reg == addr_reg);
        stat.pnd_match = (pnd_rdata_reg == addr_reg);
        stat.drop      = !seen_reg[idx_t] && (miss_inc >= miss_limit_reg);
        stat.idx_final = ((idx_reg + WW'(1)) == WW'(peer_count_reg));
        stat.out_free  = out_free;
    end

    // compaction writes at the keep pointer, append writes at the table end
    assign key_we    = cmd.keep_wr || cmd.app_wr;
    assign key_waddr = cmd.keep_wr ? w_reg[TI-1:0] : peer_count_reg[TI-1:0];
    assign key_wdata = cmd.keep_wr ? key_rdata_reg : pnd_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        if (cmd.tbl_rd)
        begin
            key_rdata_reg <= key_mem[idx_t];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pnd_push && (pending_count_reg != PC'(plt_pkg::PENDING_DEPTH)))
        begin
            pnd_mem[pending_count_reg[PI-1:0]] <= addr_reg;
        end
        if (cmd.pnd_rd)
        begin
            pnd_rdata_reg <= pnd_mem[idx_p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < plt_pkg::TABLE_DEPTH; i++)
            begin
                miss_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.keep_wr)
            begin
                miss_reg[w_reg[TI-1:0]] <= keep_count;
            end
            else if (cmd.app_wr)
            begin
                miss_reg[peer_count_reg[TI-1:0]] <= '0;
            end
            else if (cmd.miss_clr)
            begin
                miss_reg[idx_t] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg          <= '0;
            peer_count_reg    <= '0;
            pending_count_reg <= '0;
            idx_reg           <= '0;
            w_reg             <= '0;
            miss_limit_reg    <= plt_pkg::MISS_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                miss_limit_reg <= cfg_wdata;
            end

            if (cmd.load_item || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + WW'(1);
            end

            if (cmd.load_item)
            begin
                w_reg <= '0;
            end
            else if (cmd.keep_wr)
            begin
                w_reg <= w_reg + TC'(1);
            end

            if (cmd.clr_round)
            begin
                seen_reg <= '0;
            end
            else if (cmd.set_seen)
            begin
                seen_reg[idx_t] <= 1'b1;
            end

            if (cmd.clr_round)
            begin
                pending_count_reg <= '0;
            end
            else if (cmd.pnd_push && (pending_count_reg != PC'(plt_pkg::PENDING_DEPTH)))
            begin
                pending_count_reg <= pending_count_reg + PC'(1);
            end

            if (cmd.clr_table)
            begin
                peer_count_reg <= '0;
            end
            else if (cmd.commit_w)
            begin
                peer_count_reg <= w_reg;
            end
            else if (cmd.app_wr)
            begin
                peer_count_reg <= peer_count_reg + TC'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            addr_reg <= peer_addr;
        end
    end

    // output register: a beat waits here while the walk goes on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_event_reg <= cmd.emit_ev;
            out_addr_reg  <= (cmd.emit_ev == plt_pkg::EV_EMPTY) ? '0 : key_rdata_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = out_event_reg;
    assign peer_addr_out = out_addr_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

// ----- tb/tb_peer_liveness_table.sv -----
`default_nettype none

module tb_peer_liveness_table;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int TOTAL_ITEMS   = 210;
    localparam int POOL_N        = 24;

    typedef struct {
        plt_pkg::event_t            ev;
        logic [plt_pkg::ADDR_W-1:0] addr;
        logic                       last;
    } liveness_beat_t;

    class liveness_scoreboard;
        logic [plt_pkg::ADDR_W-1:0] peer_key[plt_pkg::TABLE_DEPTH];
        logic [plt_pkg::MISS_W-1:0] miss_cnt[plt_pkg::TABLE_DEPTH];
        bit                         seen_flag[plt_pkg::TABLE_DEPTH];
        int unsigned                table_len;
        logic [plt_pkg::ADDR_W-1:0] queued_key[plt_pkg::PENDING_DEPTH];
        int unsigned                queued_len;
        logic [plt_pkg::MISS_W-1:0] miss_limit_q;
        liveness_beat_t             due_beats[$];
        liveness_beat_t             fresh[$];
        int                         err_count;
        int                         n_report, n_round, n_flush, n_ignored, n_results;

        function new();
            for (int i = 0; i < plt_pkg::TABLE_DEPTH; i++) begin
                peer_key[i]  = '0;
                miss_cnt[i]  = '0;
                seen_flag[i] = 0;
            end
            table_len    = 0;
            queued_len   = 0;
            miss_limit_q = plt_pkg::MISS_RESET;
            err_count    = 0;
            n_report     = 0;
            n_round      = 0;
            n_flush      = 0;
            n_ignored    = 0;
            n_results    = 0;
        endfunction

        function void set_limit(logic [plt_pkg::MISS_W-1:0] v);
            miss_limit_q = v;
        endfunction

        function int outstanding();
            return due_beats.size();
        endfunction

        function void push(plt_pkg::event_t ev, logic [plt_pkg::ADDR_W-1:0] a);
            liveness_beat_t b;
            b.ev   = ev;
            b.addr = a;
            b.last = 1'b0;
            fresh.insert(fresh.size(), b);
        endfunction

        function void clear_round();
            for (int i = 0; i < plt_pkg::TABLE_DEPTH; i++)
                seen_flag[i] = 0;
            queued_len = 0;
        endfunction

        function void mark_peer(logic [plt_pkg::ADDR_W-1:0] a);
            for (int i = 0; i < table_len; i++) begin
                if (peer_key[i] == a) begin
                    seen_flag[i] = 1;
                    return;
                end
            end
            for (int i = 0; i < queued_len; i++)
                if (queued_key[i] == a)
                    return;
            if (queued_len < plt_pkg::PENDING_DEPTH) begin
                queued_key[queued_len] = a;
                queued_len++;
            end
        endfunction

        function void close_round();
            int unsigned                w;
            logic [plt_pkg::MISS_W-1:0] c;
            w = 0;
            for (int i = 0; i < table_len; i++) begin
                c = miss_cnt[i];
                if (seen_flag[i]) begin
                    c = '0;
                end else begin
                    if (c < plt_pkg::MISS_MAX)
                        c = c + 1'b1;
                    if (c >= miss_limit_q) begin
                        push(plt_pkg::EV_DISCONNECT, peer_key[i]);
                        continue;
                    end
                end
                peer_key[w] = peer_key[i];
                miss_cnt[w] = c;
                w++;
            end
            table_len = w;
            // queued newcomers join at the tail; overflow is silently lost
            for (int i = 0; i < queued_len; i++) begin
                if (table_len < plt_pkg::TABLE_DEPTH) begin
                    peer_key[table_len] = queued_key[i];
                    miss_cnt[table_len] = '0;
                    table_len++;
                end
            end
            clear_round();
            if (table_len == 0)
                push(plt_pkg::EV_EMPTY, '0);
            else
                for (int i = 0; i < table_len; i++)
                    push(plt_pkg::EV_MEMBER, peer_key[i]);
        endfunction

        function void flush_table();
            for (int i = 0; i < table_len; i++) begin
                push(plt_pkg::EV_DISCONNECT, peer_key[i]);
                miss_cnt[i] = '0;
            end
            table_len = 0;
            clear_round();
        endfunction

        function void note_input(plt_pkg::kind_t k, logic [plt_pkg::ADDR_W-1:0] a);
            fresh.delete();
            case (k)
                plt_pkg::KIND_REPORT: begin
                    mark_peer(a);
                    n_report++;
                end
                plt_pkg::KIND_END_ROUND: begin
                    close_round();
                    n_round++;
                end
                plt_pkg::KIND_FLUSH: begin
                    flush_table();
                    n_flush++;
                end
                default: n_ignored++;
            endcase
            if (fresh.size() > 0)
                fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[i])
                due_beats.insert(due_beats.size(), fresh[i]);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            err_count++;
        endtask

        task check_result(logic [1:0] ev, logic [plt_pkg::ADDR_W-1:0] a, logic l);
            liveness_beat_t b;
            n_results++;
            if (due_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat ev=%0d addr=%h last=%b", ev, a, l));
                return;
            end
            b = due_beats.pop_front();
            if (ev !== b.ev)
                report_mismatch($sformatf("event_res %0d, want %0d (addr %h)", ev, b.ev, b.addr));
            if (a !== b.addr)
                report_mismatch($sformatf("peer_addr_out %h, want %h", a, b.addr));
            if (l !== b.last)
                report_mismatch($sformatf("last %b, want %b (addr %h)", l, b.last, b.addr));
        endtask

        task finish_check();
            while (due_beats.size() > 0) begin
                liveness_beat_t b;
                b = due_beats.pop_front();
                report_mismatch($sformatf("missing beat ev=%0d addr=%h", b.ev, b.addr));
            end
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 kind;
    logic [plt_pkg::ADDR_W-1:0] peer_addr;
    logic                       cfg_we;
    logic [plt_pkg::MISS_W-1:0] cfg_wdata;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 event_res;
    logic [plt_pkg::ADDR_W-1:0] peer_addr_out;
    logic                       last;

    liveness_scoreboard sb = new();

    int                         cycle_count;
    int                         fed_items;
    bit                         no_idle;
    logic [plt_pkg::ADDR_W-1:0] addr_pool[POOL_N];
    logic [plt_pkg::MISS_W-1:0] limits_used[$];

    peer_liveness_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .peer_addr     (peer_addr),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .peer_addr_out (peer_addr_out),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(event_res, peer_addr_out, last);
    end

    // output backpressure: stretches of none, light, heavy and long holds
    initial
    begin
        int stretch, style, hold_left;
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            stretch = $urandom_range(20, 200);
            style   = $urandom_range(0, 3);
            repeat (stretch)
            begin
                @(negedge clk);
                if (hold_left > 0)
                begin
                    out_stall <= 1'b1;
                    hold_left--;
                end
                else if (style == 0)
                    out_stall <= 1'b0;
                else if (style == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else if (style == 2)
                    out_stall <= ($urandom_range(0, 3) != 0);
                else
                begin
                    out_stall <= 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        hold_left = $urandom_range(10, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_item(input plt_pkg::kind_t k, input logic [plt_pkg::ADDR_W-1:0] a);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        peer_addr <= a;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(k, a);
        fed_items++;
    endtask

    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        // a trailing peer report leaves no beat behind, so give it time to finish
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [plt_pkg::MISS_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        sb.set_limit(v);
        limits_used.insert(limits_used.size(), v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_N; i++)
            addr_pool[i] = $urandom();
    endtask

    task automatic run_round();
        int                         n_rep, style, pick;
        logic [plt_pkg::ADDR_W-1:0] a, prev;
        no_idle = ($urandom_range(0, 3) == 0);
        style   = $urandom_range(0, 5);
        if (style == 0)
            n_rep = $urandom_range(14, 20);
        else if (style == 1)
            n_rep = $urandom_range(0, 2);
        else
            n_rep = $urandom_range(0, 12);
        prev = addr_pool[0];
        for (int i = 0; i < n_rep; i++)
        begin
            pick = $urandom_range(0, 99);
            if (style == 0)
                a = (pick < 50) ? $urandom() : addr_pool[$urandom_range(0, POOL_N-1)];
            else if (pick < 70)
                a = addr_pool[$urandom_range(0, POOL_N-1)];
            else if (pick < 82)
                a = prev;
            else
                a = $urandom();
            if ($urandom_range(0, 19) == 0)
                send_item(plt_pkg::KIND_UNUSED, $urandom());
            send_item(plt_pkg::KIND_REPORT, a);
            prev = a;
        end
        if ($urandom_range(0, 9) == 0)
            send_item(plt_pkg::KIND_FLUSH, $urandom());
        else
            send_item(plt_pkg::KIND_END_ROUND, $urandom());
    endtask

    initial
    begin
        logic [plt_pkg::MISS_W-1:0] phase_limits[6];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = plt_pkg::KIND_REPORT;
        peer_addr   = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        cycle_count = 0;
        fed_items   = 0;
        no_idle     = 0;
        phase_limits = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd2, 4'd7};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, ignored kind, extreme addresses, duplicates
        send_item(plt_pkg::KIND_END_ROUND, 32'h0000_0000);
        send_item(plt_pkg::KIND_FLUSH,     32'hFFFF_FFFF);
        send_item(plt_pkg::KIND_UNUSED,    32'hFFFF_FFFF);
        send_item(plt_pkg::KIND_REPORT,    32'h0000_0000);
        send_item(plt_pkg::KIND_REPORT,    32'hFFFF_FFFF);
        send_item(plt_pkg::KIND_REPORT,    32'h0000_0000);
        send_item(plt_pkg::KIND_REPORT,    32'h8000_0001);
        send_item(plt_pkg::KIND_END_ROUND, 32'h0000_0000);
        send_item(plt_pkg::KIND_REPORT,    32'hFFFF_FFFF);
        send_item(plt_pkg::KIND_REPORT,    32'hFFFF_FFFF);
        send_item(plt_pkg::KIND_REPORT,    32'h1234_5678);
        send_item(plt_pkg::KIND_END_ROUND, 32'hFFFF_FFFF);
        send_item(plt_pkg::KIND_END_ROUND, 32'h5555_5555);
        send_item(plt_pkg::KIND_REPORT,    32'hA5A5_A5A5);
        send_item(plt_pkg::KIND_FLUSH,     32'h0000_0000);
        send_item(plt_pkg::KIND_END_ROUND, 32'hAAAA_AAAA);
        settle_block();

        // limit 0 on a table filled by the first round end: every unseen peer drops at once
        write_limit(4'd0);
        send_item(plt_pkg::KIND_REPORT,    32'h0000_0001);
        send_item(plt_pkg::KIND_REPORT,    32'hFFFF_FFFE);
        send_item(plt_pkg::KIND_END_ROUND, 32'h0000_0000);
        send_item(plt_pkg::KIND_REPORT,    32'h0000_0001);
        send_item(plt_pkg::KIND_END_ROUND, 32'h0000_0000);
        settle_block();

        for (int p = 0; fed_items < TOTAL_ITEMS; p++)
        begin
            write_limit(p < 6 ? phase_limits[p] : plt_pkg::MISS_W'($urandom_range(0, 15)));
            refill_pool();
            repeat ($urandom_range(3, 5))
                run_round();
            settle_block();
        end

        write_limit(plt_pkg::MISS_RESET);
        settle_block();
        sb.finish_check();

        $display("covered %0d reports, %0d round ends, %0d flushes, %0d ignored beats",
                 sb.n_report, sb.n_round, sb.n_flush, sb.n_ignored);
        $display("checked %0d result beats across %0d miss-limit settings, %0d mismatches",
                 sb.n_results, limits_used.size() + 1, sb.err_count);
        if (sb.err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
